/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, sampled on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define EEDR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("eedr check failed");

// consequent must hold in the same cycle as the antecedent
`define EEDR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eedr check failed");

// consequent must hold in the cycle after the antecedent
`define EEDR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eedr check failed");

`endif

/* rtl/core/eedr_pkg.sv */
// ---------------------------------------------------------------------------
// eedr_pkg
// shared types, constants and tables of the energy envelope recorder
// ---------------------------------------------------------------------------
package eedr_pkg;

   localparam logic [1:0] CSR_TREND_COEFF  = 2'd0;
   localparam logic [1:0] CSR_ENERGY_COEFF = 2'd1;
   localparam logic [1:0] CSR_PERIOD       = 2'd2;

   localparam logic [23:0] TREND_COEFF_RESET  = 24'd131253;
   localparam logic [23:0] ENERGY_COEFF_RESET = 24'd6989;
   localparam logic [15:0] PERIOD_RESET       = 16'd480;

   localparam logic [127:0] DENOM_255_POW6 = 128'd274941996890625;

   typedef logic [55:0] thresh_table_type [256];

   typedef struct packed {
      logic [15:0] period;
      logic        period_wr;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               measure;
   } queue_entry_type;

   // T(k) = ceil(2^48 * (2k-1)^6 / 255^6 / 2^6 * 2^6), T(0) = 0
   function automatic thresh_table_type make_thresholds();
      thresh_table_type t;
      logic [127:0]     a;
      logic [127:0]     num;
      logic [127:0]     q;
      t[0] = '0;
      for (int k = 1; k < 256; k++) begin
         a   = 128'(2 * k - 1);
         num = (a * a * a * a * a * a) << 48;
         q   = num / DENOM_255_POW6;
         if (q * DENOM_255_POW6 != num) begin
            q = q + 128'd1;
         end
         t[k] = q[55:0];
      end
      return t;
   endfunction

   localparam thresh_table_type THRESHOLDS = make_thresholds();

   function automatic logic [1:0] mag_to_code(input logic [2:0] mag);
      logic [1:0] c;
      case (mag)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd1;
         default: c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic signed [4:0] code_to_delta(input logic [2:0] code);
      logic signed [4:0] d;
      case (code)
         3'd1:    d = 5'sd1;
         3'd2:    d = 5'sd4;
         3'd3:    d = 5'sd11;
         3'd5:    d = -5'sd1;
         3'd6:    d = -5'sd4;
         3'd7:    d = -5'sd11;
         default: d = 5'sd0;
      endcase
      return d;
   endfunction

endpackage

/* rtl/core/energy_envelope_delta_recorder_core.sv */
// ---------------------------------------------------------------------------
// energy_envelope_delta_recorder_core
// a sample passes the back end through its filter states; a measurement sample also
// quantizes and codes; a record closing sample then enters the emit state and gives
// RECORD_BYTES transactions, one a cycle unstalled; one sample at a time
// a two-entry queue lets up to two samples wait while the back end is busy
// reset is synchronous, clears the levels and counters, no clearing pass
// ---------------------------------------------------------------------------
module energy_envelope_delta_recorder_core import eedr_pkg::*; #(
   parameter int RECORD_POINTS = 33,
   parameter int RECORD_BYTES  = 13
) (
   input  logic               clock,
   input  logic               reset,
   // sample transactions
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   // record byte transactions
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_record_byte,
   output logic [3:0]         rsp_byte_position,
   output logic               rsp_last_byte,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // register file
   logic [23:0]     trend_coeff_ff;
   logic [23:0]     energy_coeff_ff;
   logic [15:0]     period_ff;
   logic            csr_wr;
   cfg_type         front_cfg;

   // queue links
   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_empty;
   queue_entry_type push_data;
   queue_entry_type pop_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         CSR_TREND_COEFF:  csr_prdata = {8'd0, trend_coeff_ff};
         CSR_ENERGY_COEFF: csr_prdata = {8'd0, energy_coeff_ff};
         CSR_PERIOD:       csr_prdata = {16'd0, period_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trend_coeff_ff  <= TREND_COEFF_RESET;
         energy_coeff_ff <= ENERGY_COEFF_RESET;
         period_ff       <= PERIOD_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_TREND_COEFF:  trend_coeff_ff  <= csr_pwdata[23:0];
            CSR_ENERGY_COEFF: energy_coeff_ff <= csr_pwdata[23:0];
            CSR_PERIOD:       period_ff       <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   // a write to the period restarts the sample countdown in the front part
   // front part sees the period value being written in the same cycle
   assign front_cfg.period_wr = csr_wr && (csr_paddr[3:2] == CSR_PERIOD);
   assign front_cfg.period    = front_cfg.period_wr ? csr_pwdata[15:0] : period_ff;

   eedr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (front_cfg),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   eedr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   eedr_back #(
      .RECORD_POINTS (RECORD_POINTS),
      .RECORD_BYTES  (RECORD_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .trend_coeff       (trend_coeff_ff),
      .energy_coeff      (energy_coeff_ff),
      .queue_empty       (queue_empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_byte   (rsp_record_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte)
   );

endmodule

/* rtl/core/eedr_front.sv */
// ---------------------------------------------------------------------------
// eedr_front
// takes sample transactions and tags those that close a measurement period
// ---------------------------------------------------------------------------
module eedr_front import eedr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   input  logic signed [15:0] req_sample,
   output logic               req_stall,
   input  logic               queue_full,
   output logic               push,
   output queue_entry_type    push_data
);

   logic [15:0] samples_left_ff;
   logic [15:0] samples_left_in;
   logic [15:0] reload;
   logic        measure;

   // a zero period acts as one
   assign reload    = (cfg.period == 16'd0) ? 16'd1 : cfg.period;
   assign measure   = (samples_left_ff <= 16'd1);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign push_data.sample  = req_sample;
   assign push_data.measure = measure;

   always_comb begin
      samples_left_in = samples_left_ff;
      if (cfg.period_wr) begin
         samples_left_in = reload;
      end else if (push) begin
         samples_left_in = measure ? reload : samples_left_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_left_ff <= PERIOD_RESET;
      end else begin
         samples_left_ff <= samples_left_in;
      end
   end

endmodule

/* rtl/core/eedr_queue.sv */
// ---------------------------------------------------------------------------
// eedr_queue
// two-entry queue between the front and back parts
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eedr_queue import eedr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_data,
   input  logic            pop,
   output queue_entry_type pop_data,
   output logic            full,
   output logic            empty
);

   queue_entry_type mem_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      count_ff;
   logic            wr_ptr_in;
   logic            rd_ptr_in;
   logic [1:0]      count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EEDR_ASSERT_ALWAYS(a_count_bound, count_ff <= 2'd2)
   `EEDR_ASSERT_IMPLY(a_pop_nonempty, pop, count_ff != 2'd0)
   `EEDR_ASSERT_IMPLY(a_push_not_full, push, count_ff != 2'd2)

endmodule

/* rtl/core/eedr_back.sv */
// ---------------------------------------------------------------------------
// eedr_back
// highpass, energy smoothing, quantizing, delta coding and record output
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eedr_back import eedr_pkg::*; #(
   parameter int RECORD_POINTS = 33,
   parameter int RECORD_BYTES  = 13
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [23:0]     trend_coeff,
   input  logic [23:0]     energy_coeff,
   input  logic            queue_empty,
   input  queue_entry_type pop_data,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_record_byte,
   output logic [3:0]      rsp_byte_position,
   output logic            rsp_last_byte
);

   localparam int CODE_GROUPS = (RECORD_POINTS + 6) / 8;
   localparam int IW  = $clog2(RECORD_POINTS);
   localparam int GW  = (CODE_GROUPS > 1) ? $clog2(CODE_GROUPS) : 1;
   localparam int BW  = ($clog2(RECORD_BYTES) > 4) ? $clog2(RECORD_BYTES) : 4;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_TMUL, S_TUPD, S_SQ, S_EDIFF, S_EMUL, S_EUPD,
      S_QUANT, S_CODE, S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic signed [15:0] sample_ff, sample_in;
   logic               meas_ff, meas_in;
   logic signed [31:0] trend_ff, trend_in;
   logic [55:0]        energy_ff, energy_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        tq_ff, tq_in;
   logic [27:0]        hm_ff, hm_in;
   logic [55:0]        sq_ff, sq_in;
   logic [55:0]        ediff_ff, ediff_in;
   logic [55:0]        phi_ff, phi_in;
   logic [23:0]        plo_ff, plo_in;
   logic [7:0]         n_ff, n_in;
   logic [2:0]         qbit_ff, qbit_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [7:0]         first_ff, first_in;
   logic signed [9:0]  running_ff, running_in;
   logic [23:0]        acc_ff, acc_in;
   logic [BW-1:0]      bc_ff, bc_in;
   logic [BW-1:0]      eg_ff, eg_in;
   logic [1:0]         es_ff, es_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic [3:0]         pos_ff, pos_in;
   logic               last_ff, last_in;
   logic               store_wr;
   logic [GW-1:0]      store_idx;
   logic [23:0]        code_store_ff [CODE_GROUPS];

   logic signed [32:0] xs;
   logic signed [32:0] dval;
   logic signed [33:0] tsum;
   logic signed [32:0] hval;
   logic [31:0]        hmag;
   logic signed [56:0] ed;
   logic [55:0]        step;
   logic [7:0]         cand;
   logic signed [10:0] delta;
   logic [10:0]        dmag;
   logic [2:0]         code;
   logic [IW-1:0]      pos;
   logic [23:0]        grp;
   logic [7:0]         emit_byte;
   logic               out_free;

   assign xs       = {sample_ff[15], sample_ff, 16'd0};
   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && !queue_empty;

   assign rsp_valid         = valid_ff;
   assign rsp_record_byte   = byte_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_last_byte     = last_ff;

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      meas_in    = meas_ff;
      trend_in   = trend_ff;
      energy_in  = energy_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      tq_in      = tq_ff;
      hm_in      = hm_ff;
      sq_in      = sq_ff;
      ediff_in   = ediff_ff;
      phi_in     = phi_ff;
      plo_in     = plo_ff;
      n_in       = n_ff;
      qbit_in    = qbit_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      running_in = running_ff;
      acc_in     = acc_ff;
      bc_in      = bc_ff;
      eg_in      = eg_ff;
      es_in      = es_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      store_wr   = 1'b0;

      dval  = xs - {trend_ff[31], trend_ff};
      tsum  = neg_ff ? ({{2{trend_ff[31]}}, trend_ff} - {2'b00, tq_ff})
                     : ({{2{trend_ff[31]}}, trend_ff} + {2'b00, tq_ff});
      hval  = xs - tsum[32:0];
      hmag  = hval[32] ? 32'(-hval) : hval[31:0];
      ed    = {1'b0, sq_ff} - {1'b0, energy_ff};
      step  = phi_ff + {32'd0, plo_ff};
      cand  = n_ff | (8'd1 << qbit_ff);
      delta = $signed({3'b000, n_ff}) - {running_ff[9], running_ff};
      dmag  = delta[10] ? 11'(-delta) : delta;
      code  = {delta[10], (dmag >= 11'd8) ? 2'd3 : mag_to_code(dmag[2:0])};
      pos   = idx_ff - IW'(1);
      grp   = ((pos[2:0] == 3'd0) ? 24'd0 : acc_ff) | (24'(code) << (3 * pos[2:0]));
      store_idx = GW'(pos >> 3);

      // record byte under the emit counters
      if (bc_ff == '0) begin
         emit_byte = first_ff;
      end else if (32'(eg_ff) < 32'(CODE_GROUPS)) begin
         case (es_ff)
            2'd0:    emit_byte = code_store_ff[GW'(eg_ff)][7:0];
            2'd1:    emit_byte = code_store_ff[GW'(eg_ff)][15:8];
            default: emit_byte = code_store_ff[GW'(eg_ff)][23:16];
         endcase
      end else begin
         emit_byte = 8'd0;
      end

      if (!rsp_stall) begin
         valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               sample_in = pop_data.sample;
               meas_in   = pop_data.measure;
               state_in  = S_DIFF;
            end
         end
         S_DIFF: begin
            neg_in   = dval[32];
            mag_in   = dval[32] ? 32'(-dval) : dval[31:0];
            state_in = S_TMUL;
         end
         S_TMUL: begin
            tq_in    = 32'((56'(mag_ff) * 56'(trend_coeff)) >> 24);
            state_in = S_TUPD;
         end
         S_TUPD: begin
            trend_in = tsum[31:0];
            hm_in    = hmag[31:4];
            state_in = S_SQ;
         end
         S_SQ: begin
            sq_in    = 56'(hm_ff) * 56'(hm_ff);
            state_in = S_EDIFF;
         end
         S_EDIFF: begin
            neg_in   = ed[56];
            ediff_in = ed[56] ? 56'(-ed) : ed[55:0];
            state_in = S_EMUL;
         end
         S_EMUL: begin
            phi_in   = 56'(ediff_ff[55:24]) * 56'(energy_coeff);
            plo_in   = 24'((48'(ediff_ff[23:0]) * 48'(energy_coeff)) >> 24);
            state_in = S_EUPD;
         end
         S_EUPD: begin
            energy_in = neg_ff ? energy_ff - step : energy_ff + step;
            n_in      = 8'd0;
            qbit_in   = 3'd7;
            state_in  = meas_ff ? S_QUANT : S_IDLE;
         end
         S_QUANT: begin
            // one bit of the binary threshold search a cycle
            if (energy_ff >= THRESHOLDS[cand]) begin
               n_in = cand;
            end
            qbit_in = qbit_ff - 3'd1;
            if (qbit_ff == 3'd0) begin
               state_in = S_CODE;
            end
         end
         S_CODE: begin
            if (idx_ff == '0) begin
               first_in   = n_ff;
               running_in = $signed({2'b00, n_ff});
            end else begin
               running_in = running_ff + 10'(code_to_delta(code));
               acc_in     = grp;
               store_wr   = 1'b1;
            end
            if (32'(idx_ff) == RECORD_POINTS - 1) begin
               idx_in   = '0;
               bc_in    = '0;
               eg_in    = '0;
               es_in    = 2'd0;
               state_in = S_EMIT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = emit_byte;
               pos_in   = bc_ff[3:0];
               last_in  = (32'(bc_ff) == RECORD_BYTES - 1);
               bc_in    = bc_ff + BW'(1);
               if (bc_ff != '0) begin
                  if (es_ff == 2'd2) begin
                     es_in = 2'd0;
                     eg_in = eg_ff + BW'(1);
                  end else begin
                     es_in = es_ff + 2'd1;
                  end
               end
               if (32'(bc_ff) == RECORD_BYTES - 1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         trend_ff  <= '0;
         energy_ff <= '0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         trend_ff  <= trend_in;
         energy_ff <= energy_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
      byte_ff <= byte_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      meas_ff    <= meas_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      tq_ff      <= tq_in;
      hm_ff      <= hm_in;
      sq_ff      <= sq_in;
      ediff_ff   <= ediff_in;
      phi_ff     <= phi_in;
      plo_ff     <= plo_in;
      n_ff       <= n_in;
      qbit_ff    <= qbit_in;
      first_ff   <= first_in;
      running_ff <= running_in;
      acc_ff     <= acc_in;
      bc_ff      <= bc_in;
      eg_ff      <= eg_in;
      es_ff      <= es_in;
      if (store_wr) begin
         code_store_ff[store_idx] <= grp;
      end
   end

   `EEDR_ASSERT_IMPLY(a_emit_index_clear, state_ff == S_EMIT, idx_ff == '0)
   `EEDR_ASSERT_IMPLY(a_no_pop_when_busy, state_ff != S_IDLE, !pop)
   `EEDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_record_byte))

endmodule

/* tb/tb_energy_envelope_delta_recorder_core.sv */
// ---------------------------------------------------------------------------
// tb_energy_envelope_delta_recorder_core
// drives audio sample transactions through the envelope recorder and checks
// every record byte against an in-bench envelope predictor, over several
// register settings, with random sender bursts and receiver stalls
// ---------------------------------------------------------------------------
module tb_energy_envelope_delta_recorder_core;
   import eedr_pkg::*;

   localparam int POINTS      = 33;
   localparam int REC_BYTES   = 13;
   localparam int CODE_GROUPS = (POINTS + 6) / 8;
   localparam logic [127:0] POW6_255 = 128'd274941996890625;
   localparam logic [63:0]  LOW24    = 64'hFFFFFF;

   typedef struct packed {
      logic [7:0] value;
      logic [3:0] position;
      logic       last;
   } record_byte_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               quiet;   // no record byte can follow this transaction
   } sample_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_record_byte;
   logic [3:0]         rsp_byte_position;
   logic               rsp_last_byte;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   energy_envelope_delta_recorder_core #(
      .RECORD_POINTS(POINTS),
      .RECORD_BYTES (REC_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_byte  (rsp_record_byte),
      .rsp_byte_position(rsp_byte_position),
      .rsp_last_byte    (rsp_last_byte),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // envelope predictor state, kept apart from the block
   logic [63:0]        energy_thresh [256];
   logic [23:0]        trend_k;
   logic [23:0]        energy_k;
   logic [15:0]        period;
   logic signed [63:0] trend;
   logic [63:0]        energy;
   int unsigned        countdown;
   int unsigned        point_idx;
   logic [7:0]         opening_level;
   int                 level;
   logic [23:0]        code_groups [CODE_GROUPS];

   record_byte_type    pending_bytes [$];
   int                 fail_count;
   logic               row_quiet;
   int                 burst_left;

   // stall pattern state for the result side
   int                 stall_mode;
   int                 stall_timer;

   // ceil(2^54 * ((k - 0.5)/255)^6), worked out from scratch
   task automatic build_thresholds();
      logic [127:0] a;
      logic [127:0] num;
      logic [127:0] q;
      energy_thresh[0] = '0;
      for (int k = 1; k < 256; k++) begin
         a   = 128'(2 * k - 1);
         num = (a * a * a * a * a * a) << 48;
         q   = num / POW6_255;
         if (q * POW6_255 != num) begin
            q = q + 1;
         end
         energy_thresh[k] = q[63:0];
      end
   endtask

   function automatic int unsigned reload_count();
      return (period == 0) ? 1 : period;
   endfunction

   task automatic predictor_reset();
      trend_k     = TREND_COEFF_RESET;
      energy_k    = ENERGY_COEFF_RESET;
      period      = PERIOD_RESET;
      trend       = '0;
      energy      = '0;
      countdown   = reload_count();
      point_idx   = 0;
      opening_level = '0;
      level       = 0;
      for (int g = 0; g < CODE_GROUPS; g++) begin
         code_groups[g] = '0;
      end
   endtask

   function automatic logic [63:0] scale_by(input logic [63:0] m, input logic [23:0] c);
      return 64'(c) * (m >> 24) + ((64'(c) * (m & LOW24)) >> 24);
   endfunction

   function automatic logic [7:0] energy_byte(input logic [63:0] e);
      logic [7:0] n;
      n = '0;
      for (int k = 1; k < 256; k++) begin
         if (e >= energy_thresh[k]) begin
            n = 8'(k);
         end
      end
      return n;
   endfunction

   function automatic logic [2:0] delta_code(input int delta);
      int         mag;
      logic [2:0] c;
      mag = (delta < 0) ? -delta : delta;
      if (mag >= 8)      c = 3'd3;
      else if (mag >= 3) c = 3'd2;
      else if (mag >= 1) c = 3'd1;
      else               c = 3'd0;
      if (delta < 0) begin
         c[2] = 1'b1;
      end
      return c;
   endfunction

   function automatic int code_step(input logic [2:0] c);
      int s;
      case (c[1:0])
         2'd1:    s = 1;
         2'd2:    s = 4;
         2'd3:    s = 11;
         default: s = 0;
      endcase
      return c[2] ? -s : s;
   endfunction

   // one accepted sample: update the filters, maybe measure, maybe emit a record
   task automatic envelope_step(input logic signed [15:0] x, output int produced);
      logic signed [63:0] xs;
      logic signed [63:0] d;
      logic [63:0]        mag;
      logic [63:0]        q;
      logic [63:0]        sq;
      logic [7:0]         b;
      logic [2:0]         c;
      int                 p;
      record_byte_type    rb;
      produced = 0;
      xs  = 64'(x) <<< 16;
      d   = xs - trend;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q   = (mag * 64'(trend_k)) >> 24;
      trend = (d < 0) ? trend - $signed(q) : trend + $signed(q);
      d   = xs - trend;
      mag = ((d < 0) ? 64'(-d) : 64'(d)) >> 4;
      sq  = mag * mag;
      if (sq >= energy) energy = energy + scale_by(sq - energy, energy_k);
      else              energy = energy - scale_by(energy - sq, energy_k);
      if (countdown > 1) begin
         countdown--;
         return;
      end
      countdown = reload_count();
      b = energy_byte(energy);
      if (point_idx == 0) begin
         opening_level = b;
         level         = b;
      end else begin
         p = point_idx - 1;
         c = delta_code(int'(b) - level);
         level += code_step(c);
         if (p / 8 < CODE_GROUPS) begin
            if (p % 8 == 0) begin
               code_groups[p / 8] = '0;
            end
            code_groups[p / 8] = code_groups[p / 8] | (24'(c) << (3 * (p % 8)));
         end
      end
      point_idx++;
      if (point_idx < POINTS) begin
         return;
      end
      point_idx = 0;
      for (int i = 0; i < REC_BYTES; i++) begin
         if (i == 0) begin
            rb.value = opening_level;
         end else if ((i - 1) / 3 < CODE_GROUPS) begin
            rb.value = 8'(code_groups[(i - 1) / 3] >> (8 * ((i - 1) % 3)));
         end else begin
            rb.value = '0;
         end
         rb.position = 4'(i);
         rb.last     = (i == REC_BYTES - 1);
         pending_bytes.push_back(rb);
      end
      produced = REC_BYTES;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // accepted sample transactions feed the predictor, accepted bytes are checked
   always @(posedge clock) begin
      int              n;
      record_byte_type got;
      record_byte_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            envelope_step(req_sample, n);
            if (row_quiet && n != 0) begin
               $display("%0t: record emitted on a quiet row, expected 0 bytes, got %0d",
                        $realtime, n);
               fail_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_record_byte, rsp_byte_position, rsp_last_byte};
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected record byte, expected none, got %h/%0d/%0b",
                        $realtime, got.value, got.position, got.last);
               fail_count++;
            end else begin
               want = pending_bytes.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: record_byte expected %h, got %h",
                           $realtime, want.value, got.value);
                  fail_count++;
               end
               if (got.position !== want.position) begin
                  $display("%0t: byte_position expected %0d, got %0d",
                           $realtime, want.position, got.position);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last_byte expected %0b, got %0b",
                           $realtime, want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver stall pattern: free flow, heavy, light and long stall runs
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(3);
         stall_timer = $urandom_range(20, 120);
      end
      stall_timer--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(1) == 0);
         2:       rsp_stall <= ($urandom_range(7) == 0);
         default: rsp_stall <= ((stall_timer % 10) < 6);
      endcase
   end

   // one register write: setup then access, written on the access edge
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = 4'(idx) << 2;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         CSR_TREND_COEFF:  trend_k  = value[23:0];
         CSR_ENERGY_COEFF: energy_k = value[23:0];
         CSR_PERIOD: begin
            period    = value[15:0];
            countdown = reload_count();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // one sample transaction, sender bursts with random gaps
   task automatic send_sample(input logic signed [15:0] x);
      req_sample = x;
      req_valid  = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 8);
      end
   endtask

   // hold the sender until every expected byte is out and the back end is quiet
   task automatic drain();
      req_valid = 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_regs(input logic [23:0] tk, input logic [23:0] ek,
                           input logic [15:0] per);
      drain();
      csr_write(CSR_TREND_COEFF, 32'(tk));
      csr_write(CSR_ENERGY_COEFF, 32'(ek));
      csr_write(CSR_PERIOD, 32'(per));
   endtask

   // random audio: level held for a stretch so the envelope moves in steps
   task automatic send_audio(input int count);
      int amp;
      int left;
      int s;
      left = 0;
      amp  = 0;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            case ($urandom_range(5))
               0:       amp = 0;
               1:       amp = 64;
               2:       amp = 1024;
               3:       amp = 8192;
               4:       amp = 20000;
               default: amp = 32767;
            endcase
            left = $urandom_range(4, 30);
         end
         left--;
         case ($urandom_range(3))
            0:       s = (i % 2) ? amp : -amp - (amp == 32767);
            1:       s = $signed(16'($urandom));
            default: s = int'($urandom_range(2 * amp)) - amp;
         endcase
         send_sample(16'(s));
      end
   endtask

   // directed samples: extremes, sign edge, alternating bit patterns
   sample_row_type directed_rows [] = '{
      '{16'sh7FFF, 1'b1}, '{16'sh8000, 1'b1}, '{16'sh0000, 1'b1}, '{16'shFFFF, 1'b1},
      '{16'sh0001, 1'b1}, '{16'sh5555, 1'b1}, '{16'shAAAA, 1'b1}, '{16'sh7FFF, 1'b1},
      '{16'sh7FFF, 1'b1}, '{16'sh8000, 1'b1}, '{16'sh8000, 1'b1}, '{16'sh0000, 1'b1},
      '{16'sh00FF, 1'b1}, '{16'shFF00, 1'b1}, '{16'sh4000, 1'b1}, '{16'shC000, 1'b1},
      '{16'sh7FFF, 1'b1}, '{16'sh8000, 1'b1}, '{16'sh1234, 1'b1}, '{16'shEDCB, 1'b1}
   };

   initial begin
      fail_count  = 0;
      row_quiet   = 1'b0;
      burst_left  = 0;
      stall_mode  = 0;
      stall_timer = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      build_thresholds();
      predictor_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows at reset settings: a 480 sample period cannot close a record
      foreach (directed_rows[i]) begin
         row_quiet = directed_rows[i].quiet;
         send_sample(directed_rows[i].sample);
      end
      drain();
      row_quiet = 1'b0;

      // fastest measuring, no trend tracking, fastest energy response
      set_regs(24'd0, 24'hFFFFFF, 16'd1);
      send_audio(110);
      // zero period behaves as one, full trend tracking, frozen energy
      set_regs(24'hFFFFFF, 24'd0, 16'd0);
      send_audio(70);
      // longest period: nothing measured within these samples
      set_regs(24'd200000, 24'd5000000, 16'hFFFF);
      send_audio(15);
      // random coefficients, short periods
      for (int ph = 0; ph < 4; ph++) begin
         set_regs(24'($urandom), 24'($urandom_range(100000, 24'hFFFFFF)),
                  16'($urandom_range(1, 3)));
         send_audio(70);
      end

      drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/eedr_pkg.sv
rtl/core/eedr_front.sv
rtl/core/eedr_queue.sv
rtl/core/eedr_back.sv
rtl/core/energy_envelope_delta_recorder_core.sv
tb/tb_energy_envelope_delta_recorder_core.sv
